FILE: src/pfu_pkg.sv
`default_nettype none

package pfu_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam int PAL_DW = 24;
	localparam logic [PAL_DW-1:0] PAL_WHITE = 24'hFFFFFF;
	localparam logic signed [8:0] FADE_FULL_POS = 9'sd255;
	localparam logic signed [8:0] FADE_FULL_NEG = -9'sd255;

	typedef enum logic [2:0] {
		FN_WRITE    = 3'd0,
		FN_CLEAR    = 3'd1,
		FN_FADE_IN  = 3'd2,
		FN_FADE_OUT = 3'd3,
		FN_TICK     = 3'd4,
		FN_READ     = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_IN   = 2'd1,
		DIR_OUT  = 2'd2
	} dir_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic sat;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
	} sts_t;

	function automatic logic [7:0] sat_chan(input logic [7:0] chan,
			input logic signed [8:0] off);
		logic signed [10:0] v;
		v = $signed({3'b000, chan}) + $signed({{2{off[8]}}, off});
		if (v < 11'sd0) begin
			return 8'd0;
		end else if (v > 11'sd255) begin
			return 8'd255;
		end else begin
			return v[7:0];
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/palette_fade_unit.sv
`default_nettype none

// palette with brightness fade. each input word carries one function (write entry, clear,
// fade in, fade out, frame tick, read entry) and gives exactly one result word. one word is
// in flight at a time: a read passes through an extra state, ST_READ, that every other
// function skips; it waits for the registered read port of the palette ram. a clear takes
// no extra time: a bank of per-entry valid bits is dropped together with the write of
// white into entry 0, so there is no clearing pass after reset or on clear. results sit
// in an output register until taken; out_stall only lengthens the wait and never drops
// a word.
module palette_fade_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        func,
	input  wire logic [7:0]        entry_index,
	input  wire logic [7:0]        red_in,
	input  wire logic [7:0]        green_in,
	input  wire logic [7:0]        blue_in,
	input  wire logic [7:0]        fade_steps,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   load_strobe,
	output logic                   fade_active,
	output logic signed [8:0]      shown_offset,
	output logic [7:0]             red_out,
	output logic [7:0]             green_out,
	output logic [7:0]             blue_out
);

	import pfu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: idle, ram read wait, result hold
	pfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	// palette ram, fade state and result register
	pfu_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.entry_index (entry_index),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.fade_steps  (fade_steps),
		.sts         (sts),
		.load_strobe (load_strobe),
		.fade_active (fade_active),
		.shown_offset(shown_offset),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out)
	);

	// a waiting result blocks the input side
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result word waits");

	// one word at a time
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second word accepted back to back");

	// a nonzero shown offset only exists during a fade
	a_offset_needs_fade: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (shown_offset != 9'sd0)) |-> fade_active)
		else $error("offset shown with no fade running");

endmodule

`default_nettype wire

FILE: src/pfu_ram.sv
`default_nettype none

module pfu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/pfu_ctrl.sv
`default_nettype none

module pfu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_stall,
	input  wire pfu_pkg::sts_t sts,
	output logic               in_stall,
	output logic               out_valid,
	output pfu_pkg::cmd_t      cmd
);

	import pfu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (sts.is_read) begin
							state_q <= ST_READ;
						end else begin
							state_q     <= ST_OUT;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					state_q     <= ST_OUT;
					out_valid_q <= 1'b1;
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.exec  = in_valid && (state_q == ST_IDLE);
	assign cmd.sat   = (state_q == ST_READ);

endmodule

`default_nettype wire

FILE: src/pfu_datapath.sv
`default_nettype none

module pfu_datapath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pfu_pkg::cmd_t          cmd,
	input  wire logic [2:0]             func,
	input  wire logic [7:0]             entry_index,
	input  wire logic [7:0]             red_in,
	input  wire logic [7:0]             green_in,
	input  wire logic [7:0]             blue_in,
	input  wire logic [7:0]             fade_steps,
	output pfu_pkg::sts_t               sts,
	output logic                        load_strobe,
	output logic                        fade_active,
	output logic signed [8:0]           shown_offset,
	output logic [7:0]                  red_out,
	output logic [7:0]                  green_out,
	output logic [7:0]                  blue_out
);

	import pfu_pkg::*;

	// architectural state
	logic [PALETTE_ENTRIES-1:0] valid_q;
	logic                       dirty_q;
	dir_t                       dir_q;
	logic signed [8:0]          step_q;
	logic signed [8:0]          time_q;
	logic signed [8:0]          offset_q;

	// result word
	logic                       strobe_q;
	logic                       active_q;
	logic signed [8:0]          shown_q;
	logic [7:0]                 red_q;
	logic [7:0]                 green_q;
	logic [7:0]                 blue_q;

	logic                       rd_ok_s1;

	logic                       in_range;
	logic [PAL_AW-1:0]          addr;
	logic                       ram_we;
	logic [PAL_AW-1:0]          ram_waddr;
	logic [PAL_DW-1:0]          ram_wdata;
	logic                       ram_re;
	logic [PAL_DW-1:0]          ram_rdata;
	logic [PAL_DW-1:0]          rd_word;

	logic                       n_dirty;
	dir_t                       n_dir;
	logic signed [8:0]          n_step;
	logic signed [8:0]          n_time;
	logic signed [8:0]          n_offset;
	logic                       n_strobe;
	logic signed [8:0]          step_mag;
	logic signed [9:0]          tick_sum;
	logic                       going;

	assign in_range = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
	assign addr     = entry_index[PAL_AW-1:0];
	assign sts.is_read = (func == FN_READ);

	assign step_mag = (fade_steps == 8'd0) ? 9'sd1 : $signed({1'b0, fade_steps});
	assign tick_sum = {time_q[8], time_q} + {step_q[8], step_q};
	assign going    = (dir_q == DIR_OUT) ? (tick_sum > 10'sd0) : (tick_sum < 10'sd0);

	always_comb begin
		n_dirty  = dirty_q;
		n_dir    = dir_q;
		n_step   = step_q;
		n_time   = time_q;
		n_offset = offset_q;
		n_strobe = 1'b0;
		case (func) inside
			FN_WRITE, FN_CLEAR: begin
				n_dirty = 1'b1;
			end
			FN_FADE_IN: begin
				if (dir_q == DIR_IDLE) begin
					n_step = step_mag;
					n_time = FADE_FULL_NEG;
					n_dir  = DIR_IN;
				end
			end
			FN_FADE_OUT: begin
				if (dir_q == DIR_IDLE) begin
					n_step = -step_mag;
					n_time = FADE_FULL_POS;
					n_dir  = DIR_OUT;
				end
			end
			FN_TICK: begin
				n_dirty = 1'b0;
				if (dir_q == DIR_IDLE) begin
					n_strobe = dirty_q;
				end else begin
					n_strobe = 1'b1;
					n_time   = tick_sum[8:0];
					if (going) begin
						n_offset = time_q;
					end else begin
						n_dir    = DIR_IDLE;
						n_offset = 9'sd0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// clear writes white into entry 0 and drops every other valid bit
	assign ram_we    = cmd.exec && ((func == FN_CLEAR) || ((func == FN_WRITE) && in_range));
	assign ram_waddr = (func == FN_CLEAR) ? '0 : addr;
	assign ram_wdata = (func == FN_CLEAR) ? PAL_WHITE : {red_in, green_in, blue_in};
	assign ram_re    = cmd.exec && (func == FN_READ);

	// entries not written since reset or clear are black, still faded
	assign rd_word   = rd_ok_s1 ? ram_rdata : '0;

	pfu_ram #(
		.WIDTH(PAL_DW),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(addr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			dirty_q  <= 1'b0;
			dir_q    <= DIR_IDLE;
			step_q   <= 9'sd0;
			time_q   <= 9'sd0;
			offset_q <= 9'sd0;
		end else if (cmd.exec) begin
			dirty_q  <= n_dirty;
			dir_q    <= n_dir;
			step_q   <= n_step;
			time_q   <= n_time;
			offset_q <= n_offset;
			if (func == FN_CLEAR) begin
				valid_q <= {{(PALETTE_ENTRIES-1){1'b0}}, 1'b1};
			end else if ((func == FN_WRITE) && in_range) begin
				valid_q[addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			strobe_q <= n_strobe;
			active_q <= (n_dir != DIR_IDLE);
			shown_q  <= n_offset;
			red_q    <= 8'd0;
			green_q  <= 8'd0;
			blue_q   <= 8'd0;
			rd_ok_s1 <= in_range && valid_q[addr];
		end else if (cmd.sat) begin
			red_q   <= sat_chan(rd_word[23:16], offset_q);
			green_q <= sat_chan(rd_word[15:8], offset_q);
			blue_q  <= sat_chan(rd_word[7:0], offset_q);
		end
	end

	assign load_strobe  = strobe_q;
	assign fade_active  = active_q;
	assign shown_offset = shown_q;
	assign red_out      = red_q;
	assign green_out    = green_q;
	assign blue_out     = blue_q;

endmodule

`default_nettype wire
